// File: src/i2of5_pkg.sv
// Package for the interleaved 2 of 5 bar encoder: payload types, constants, digit patterns.
`timescale 1ns / 1ps

package i2of5_pkg;

    localparam logic [7:0] START_PATTERN = 8'hCC;
    localparam logic [7:0] STOP_PATTERN  = 8'hF3;
    localparam logic [7:0] DIGIT_BASE    = 8'h30;
    localparam logic [3:0] MAX_PAIRS_RST = 4'd12;

    // Most bytes one pair can produce: 8 start + 28 pair + 8 stop, padded
    localparam int unsigned BUF_BYTES = 6;
    localparam int unsigned BUF_BITS  = BUF_BYTES * 8;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [7:0] char_bars;
        logic [7:0] char_spaces;
        logic       first_pair;
        logic       last_pair;
    } pair_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_of_symbol;
        logic [1:0] status;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[DIGIT_BASE:DIGIT_BASE + 8'd9]};
    endfunction

    // Wide-element mask per digit, bit 4 is the first element
    function automatic logic [4:0] digit_wides(input logic [3:0] d);
        logic [4:0] w;
        case (d)
            4'd0:    w = 5'h06;
            4'd1:    w = 5'h11;
            4'd2:    w = 5'h09;
            4'd3:    w = 5'h18;
            4'd4:    w = 5'h05;
            4'd5:    w = 5'h14;
            4'd6:    w = 5'h0C;
            4'd7:    w = 5'h03;
            4'd8:    w = 5'h12;
            4'd9:    w = 5'h0A;
            default: w = 5'h00;
        endcase
        return w;
    endfunction

    // Interleaved bars and spaces of one pair; always 28 modules
    function automatic logic [27:0] pair_modules(input logic [4:0] wb, input logic [4:0] ws);
        logic [27:0] pat;
        pat = '0;
        for (int j = 0; j < 5; j++)
        begin
            pat = wb[4 - j] ? {pat[23:0], 4'hF} : {pat[25:0], 2'b11};
            pat = ws[4 - j] ? {pat[23:0], 4'h0} : {pat[25:0], 2'b00};
        end
        return pat;
    endfunction

endpackage

// File: src/interleaved_2of5_bar_encoder_core.sv
// Interleaved 2 of 5 bar encoder: pair input register, one-pass packer, byte output buffer.
// A transferred pair is registered in the input register, then packed into the output buffer once that is free.
// Throughput: one output byte per cycle while res_stall is low; a pair produces 3 to 6
//   bytes, an error pair a single byte, and a dropped pair none.
// The next pair is packed in the cycle the previous pair's last byte transfers.
// Reset (rst_n low, asynchronous): channels empty, symbol state cleared, max_pairs = 12.
`timescale 1ns / 1ps

module interleaved_2of5_bar_encoder_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  i2of5_pkg::pair_t pair_data,
    output logic             res_valid,
    input  logic             res_stall,
    output i2of5_pkg::result_t res_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data
);
    import i2of5_pkg::*;

    pair_t                 in_reg;
    logic                  in_vld_reg;
    logic [3:0]            max_pairs_reg;
    logic [6:0]            partial_modules_reg, partial_modules_next;
    logic [2:0]            partial_count_reg, partial_count_next;
    logic [3:0]            pairs_seen_reg, pairs_seen_next;
    logic                  symbol_aborted_reg, symbol_aborted_next;
    logic [BUF_BITS-1:0]   buf_reg, buf_next;
    logic [2:0]            buf_cnt_reg, buf_cnt_next;
    logic                  buf_end_reg, buf_end_next;
    logic [1:0]            buf_status_reg, buf_status_next;

    logic                  res_xfer;
    logic                  consume;
    logic                  ignore;
    logic [3:0]            ps_eff;
    logic [1:0]            err_status;
    logic [7:0]            prefix;
    logic [3:0]            plen;
    logic [27:0]           pair_bits;
    logic [43:0]           seq;
    logic [BUF_BITS-1:0]   aligned;
    logic [5:0]            ntot;
    logic [2:0]            nbytes;
    logic [2:0]            rem;
    logic [6:0]            rem_mask;

    assign cfg_ready = 1'b1;
    assign res_valid = buf_cnt_reg != 3'd0;
    assign res_xfer  = res_valid && !res_stall;

    // Load the buffer once it is empty or its final byte is leaving
    assign consume    = in_vld_reg && (buf_cnt_reg == 3'd0 || (buf_cnt_reg == 3'd1 && res_xfer));
    assign pair_stall = in_vld_reg && !consume;

    assign res_data.packed_byte   = buf_reg[BUF_BITS-1 -: 8];
    assign res_data.end_of_symbol = buf_end_reg && buf_cnt_reg == 3'd1;
    assign res_data.status        = buf_status_reg;

    always_comb
    begin
        ignore = !in_reg.first_pair && symbol_aborted_reg;
        ps_eff = in_reg.first_pair ? 4'd0 : pairs_seen_reg;

        if (ps_eff >= max_pairs_reg)
            err_status = STATUS_TOO_MANY;
        else if (!is_digit(in_reg.char_bars) || !is_digit(in_reg.char_spaces))
            err_status = STATUS_BAD_CHAR;
        else
            err_status = STATUS_OK;

        // a first pair starts a new symbol and discards any carried modules, so the prefix is one or the other
        prefix = in_reg.first_pair ? START_PATTERN : {1'b0, partial_modules_reg};
        plen   = in_reg.first_pair ? 4'd8 : {1'b0, partial_count_reg};

        pair_bits = pair_modules(digit_wides(4'(in_reg.char_bars - DIGIT_BASE)),
                                 digit_wides(4'(in_reg.char_spaces - DIGIT_BASE)));
        seq       = {prefix, pair_bits, in_reg.last_pair ? STOP_PATTERN : 8'h00};
        aligned   = {4'b0, seq} << (4'd12 - plen);

        ntot   = 6'(plen) + 6'd28 + (in_reg.last_pair ? 6'd8 : 6'd0);
        nbytes = in_reg.last_pair ? 3'((ntot + 6'd7) >> 3) : ntot[5:3];
        rem    = ntot[2:0];
        rem_mask = 7'((8'd1 << rem) - 8'd1);

        partial_modules_next = partial_modules_reg;
        partial_count_next   = partial_count_reg;
        pairs_seen_next      = pairs_seen_reg;
        symbol_aborted_next  = symbol_aborted_reg;
        buf_next             = buf_reg;
        buf_cnt_next         = buf_cnt_reg;
        buf_end_next         = buf_end_reg;
        buf_status_next      = buf_status_reg;

        if (res_xfer)
        begin
            buf_next     = {buf_reg[BUF_BITS-9:0], 8'h00};
            buf_cnt_next = buf_cnt_reg - 3'd1;
        end

        if (consume)
        begin
            if (ignore)
            begin
                buf_cnt_next = 3'd0;
            end
            else if (err_status != STATUS_OK)
            begin
                buf_next             = '0;
                buf_cnt_next         = 3'd1;
                buf_end_next         = 1'b1;
                buf_status_next      = err_status;
                partial_modules_next = '0;
                partial_count_next   = '0;
                pairs_seen_next      = '0;
                symbol_aborted_next  = 1'b1;
            end
            else
            begin
                buf_next            = aligned;
                buf_cnt_next        = nbytes;
                buf_end_next        = in_reg.last_pair;
                buf_status_next     = STATUS_OK;
                symbol_aborted_next = 1'b0;
                if (in_reg.last_pair)
                begin
                    partial_modules_next = '0;
                    partial_count_next   = '0;
                    pairs_seen_next      = '0;
                end
                else
                begin
                    partial_modules_next = seq[14:8] & rem_mask;
                    partial_count_next   = rem;
                    pairs_seen_next      = ps_eff + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            max_pairs_reg       <= MAX_PAIRS_RST;
            partial_modules_reg <= '0;
            partial_count_reg   <= '0;
            pairs_seen_reg      <= '0;
            symbol_aborted_reg  <= 1'b0;
            buf_cnt_reg         <= '0;
            buf_end_reg         <= 1'b0;
            buf_status_reg      <= STATUS_OK;
        end
        else
        begin
            if (pair_valid && !pair_stall)
                in_vld_reg <= 1'b1;
            else if (consume)
                in_vld_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                max_pairs_reg <= cfg_data;
            partial_modules_reg <= partial_modules_next;
            partial_count_reg   <= partial_count_next;
            pairs_seen_reg      <= pairs_seen_next;
            symbol_aborted_reg  <= symbol_aborted_next;
            buf_cnt_reg         <= buf_cnt_next;
            buf_end_reg         <= buf_end_next;
            buf_status_reg      <= buf_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid && !pair_stall)
            in_reg <= pair_data;
        buf_reg <= buf_next;
    end

`ifndef SYNTH
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'(BUF_BYTES))
        else $error("output buffer count out of range");

    a_stall_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && buf_cnt_reg > 3'd1) |-> pair_stall)
        else $error("pair taken while buffer still holds several bytes");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.status != STATUS_OK) |->
            (buf_cnt_reg == 3'd1 && res_data.end_of_symbol && res_data.packed_byte == 8'h00))
        else $error("error result is not a single flagged zero byte");

    a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_modules_reg >> partial_count_reg) == 7'd0)
        else $error("carried modules exceed carried count");

    a_abort_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && !ignore && err_status != STATUS_OK) |=> symbol_aborted_reg)
        else $error("symbol not aborted after error");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the interleaved 2 of 5 bar encoder core.
`timescale 1ns / 1ps

module testbench;

    import i2of5_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int KEEP          = -1;

    // Wide-element masks, digit d at bits [5*d +: 5], first element in bit 4
    localparam logic [49:0] WIDE_MASKS = {5'h0A, 5'h12, 5'h03, 5'h0C, 5'h14,
                                          5'h05, 5'h18, 5'h09, 5'h11, 5'h06};

    localparam result_t BAD_CHAR_END = {8'h00, 1'b1, STATUS_BAD_CHAR};
    localparam result_t TOO_MANY_END = {8'h00, 1'b1, STATUS_TOO_MANY};
    localparam result_t NO_RESULT    = '0;

    typedef struct {
        int      set_max;   // register value written before the row, KEEP for none
        pair_t   pair;
        bit      typed;     // expected result written in the row
        result_t want;
    } pair_row_t;

    logic       clk;
    logic       rst_n;
    logic       pair_valid;
    logic       pair_stall;
    pair_t      pair_data;
    logic       res_valid;
    logic       res_stall;
    result_t    res_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    // encoder state as the checker sees it
    logic [6:0] held_bits;
    logic [2:0] held_count;
    logic [3:0] pair_count;
    logic       aborted;
    logic [3:0] max_pairs_set;

    result_t    byte_queue[$];
    result_t    oldest;
    pair_row_t  pair_rows[24];
    int         error_count;
    int         cycle_count;
    int         sent_count;
    int         burst_left;

    interleaved_2of5_bar_encoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_data  (pair_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $time, byte_queue.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic bit is_numeral(logic [7:0] c);
        return c >= DIGIT_BASE && c <= DIGIT_BASE + 8'd9;
    endfunction

    // Works out the bytes one accepted pair produces and updates the symbol state
    task automatic encode_pair(input pair_t p, input bit record, output bit ignored);
        logic [63:0] acc;
        logic [4:0]  wb;
        logic [4:0]  ws;
        logic [1:0]  code;
        result_t     r;
        int          nbits;
        int          bw;
        int          sw;
        int          nb;
        int          rem;
        ignored = 1'b0;
        if (p.first_pair)
        begin
            held_bits  = '0;
            held_count = '0;
            pair_count = '0;
            aborted    = 1'b0;
        end
        else if (aborted)
        begin
            ignored = 1'b1;
            return;
        end

        code = STATUS_OK;
        if (pair_count >= max_pairs_set)
            code = STATUS_TOO_MANY;
        else if (!is_numeral(p.char_bars) || !is_numeral(p.char_spaces))
            code = STATUS_BAD_CHAR;
        if (code != STATUS_OK)
        begin
            held_bits  = '0;
            held_count = '0;
            pair_count = '0;
            aborted    = 1'b1;
            r.packed_byte   = 8'h00;
            r.end_of_symbol = 1'b1;
            r.status        = code;
            if (record)
                byte_queue.push_back(r);
            return;
        end

        acc   = 64'(held_bits);
        nbits = int'(held_count);
        if (p.first_pair)
        begin
            acc   = (acc << 8) | 64'(START_PATTERN);
            nbits += 8;
        end
        wb = WIDE_MASKS[int'(p.char_bars - DIGIT_BASE) * 5 +: 5];
        ws = WIDE_MASKS[int'(p.char_spaces - DIGIT_BASE) * 5 +: 5];
        for (int j = 0; j < 5; j++)
        begin
            bw    = wb[4 - j] ? 4 : 2;
            sw    = ws[4 - j] ? 4 : 2;
            acc   = (acc << bw) | ((64'd1 << bw) - 64'd1);
            acc   = acc << sw;
            nbits += bw + sw;
        end
        pair_count = pair_count + 4'd1;

        if (p.last_pair)
        begin
            acc   = (acc << 8) | 64'(STOP_PATTERN);
            nbits += 8;
            if (nbits % 8 != 0)
            begin
                acc   = acc << (8 - nbits % 8);
                nbits += 8 - nbits % 8;
            end
        end

        nb = nbits / 8;
        for (int k = 0; k < nb; k++)
        begin
            r.packed_byte   = acc[nbits - 8 * (k + 1) +: 8];
            r.end_of_symbol = p.last_pair && (k == nb - 1);
            r.status        = STATUS_OK;
            if (record)
                byte_queue.push_back(r);
        end

        if (p.last_pair)
        begin
            held_bits  = '0;
            held_count = '0;
            pair_count = '0;
        end
        else
        begin
            rem        = nbits % 8;
            held_count = 3'(rem);
            held_bits  = 7'(acc & ((64'd1 << rem) - 64'd1));
        end
    endtask

    // One pair transfer, with the sender's burst and gap pattern around it
    task automatic send_pair(input pair_t p, input bit typed, input result_t want);
        int gap;
        bit ignored;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pair_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        pair_valid <= 1'b1;
        pair_data  <= p;
        do
            @(posedge clk);
        while (pair_stall);
        encode_pair(p, !typed, ignored);
        if (typed)
            byte_queue.push_back(want);
        if (!ignored)
            sent_count++;
    endtask

    // Drain the block, then write max_pairs
    task automatic set_max_pairs(input logic [3:0] value);
        pair_valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        // dropped pairs give no byte, so let the core settle too
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        max_pairs_set = value;
        burst_left    = 0;
    endtask

    task automatic send_symbol(input int limit);
        pair_t p;
        int    kind;
        int    len;
        int    bad_at;
        kind   = $urandom_range(0, 9);
        len    = $urandom_range(1, (limit == 0) ? 2 : limit);
        if (kind == 0)
            len += $urandom_range(1, 2);    // may run past the pair limit
        bad_at = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++)
        begin
            p.char_bars   = DIGIT_BASE + 8'($urandom_range(0, 9));
            p.char_spaces = DIGIT_BASE + 8'($urandom_range(0, 9));
            p.first_pair  = (k == 0);
            p.last_pair   = (k == len - 1);
            if (kind == 1 && k == bad_at)
            begin
                if ($urandom_range(0, 1) == 1)
                    p.char_bars = 8'($urandom);
                else
                    p.char_spaces = 8'($urandom);
            end
            if (kind == 2)
                p = pair_t'(18'($urandom));
            if (kind == 3 && k == 0)
                p.first_pair = 1'b0;
            send_pair(p, 1'b0, NO_RESULT);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (byte_queue.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, %s %h eos %b status %0d",
                         $time, "got byte", res_data.packed_byte,
                         res_data.end_of_symbol, res_data.status);
                error_count++;
            end
            else
            begin
                oldest = byte_queue.pop_front();
                if (res_data.packed_byte !== oldest.packed_byte
                    || res_data.end_of_symbol !== oldest.end_of_symbol
                    || res_data.status !== oldest.status)
                begin
                    $display("%0t: mismatch: expected byte %h eos %b status %0d,%s",
                             $time, oldest.packed_byte, oldest.end_of_symbol,
                             oldest.status, " got");
                    $display("%0t:   actual byte %h eos %b status %0d",
                             $time, res_data.packed_byte, res_data.end_of_symbol,
                             res_data.status);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall, switching at random between four patterns
    initial
    begin
        int stall_mode;
        int stall_left;
        res_stall  = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 1) == 1);
                default: res_stall <= (stall_left % 8 < 3);
            endcase
        end
    end

    initial
    begin
        int phase_max[6];
        int phase_items[6];
        int start_count;
        rst_n      = 1'b0;
        pair_valid = 1'b0;
        pair_data  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        error_count   = 0;
        cycle_count   = 0;
        sent_count    = 0;
        burst_left    = 0;
        held_bits     = '0;
        held_count    = '0;
        pair_count    = '0;
        aborted       = 1'b0;
        max_pairs_set = MAX_PAIRS_RST;

        pair_rows = '{
            '{KEEP, {"0", "0", 1'b1, 1'b1}, 1'b0, NO_RESULT},
            '{KEEP, {"9", "9", 1'b1, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"5", "4", 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"8", "1", 1'b0, 1'b1}, 1'b0, NO_RESULT},
            '{KEEP, {8'h2F, "0", 1'b1, 1'b0}, 1'b1, BAD_CHAR_END},
            '{KEEP, {"1", "2", 1'b0, 1'b0}, 1'b0, NO_RESULT},     // dropped, symbol aborted
            '{KEEP, {"0", 8'h3A, 1'b1, 1'b0}, 1'b1, BAD_CHAR_END},
            '{KEEP, {8'hFF, 8'h00, 1'b1, 1'b1}, 1'b1, BAD_CHAR_END},
            '{KEEP, {"7", "3", 1'b1, 1'b1}, 1'b0, NO_RESULT},
            '{KEEP, {"2", "6", 1'b0, 1'b1}, 1'b0, NO_RESULT},     // no symbol open
            '{KEEP, {"1", "1", 1'b1, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"4", "4", 1'b1, 1'b0}, 1'b0, NO_RESULT},     // restart while open
            '{KEEP, {"0", "1", 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"2", "3", 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"6", "7", 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"8", "9", 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"3", "5", 1'b0, 1'b1}, 1'b0, NO_RESULT},
            '{1,    {"3", "4", 1'b1, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"5", "6", 1'b0, 1'b0}, 1'b1, TOO_MANY_END},
            '{KEEP, {"1", "1", 1'b1, 1'b1}, 1'b0, NO_RESULT},
            '{KEEP, {"9", "9", 1'b1, 1'b0}, 1'b0, NO_RESULT},
            '{KEEP, {"A", 8'h00, 1'b0, 1'b1}, 1'b1, TOO_MANY_END}, // limit beats bad char
            '{0,    {"0", "0", 1'b1, 1'b0}, 1'b1, TOO_MANY_END},
            '{15,   {"1", "2", 1'b1, 1'b1}, 1'b0, NO_RESULT}
        };
        phase_max   = '{15, 1, 5, 0, 8, 12};
        phase_items = '{55, 45, 50, 10, 50, 50};
        phase_max[4] = $urandom_range(2, 11);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pair_rows[i])
        begin
            if (pair_rows[i].set_max != KEEP)
                set_max_pairs(4'(pair_rows[i].set_max));
            send_pair(pair_rows[i].pair, pair_rows[i].typed, pair_rows[i].want);
        end

        foreach (phase_max[ph])
        begin
            set_max_pairs(4'(phase_max[ph]));
            start_count = sent_count;
            while (sent_count - start_count < phase_items[ph])
                send_symbol(phase_max[ph]);
        end

        pair_valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
